// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; they compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent check on the rising edge of clk, held off while rst is high.
`define CRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Concurrent check that a condition never holds.
`define CRM_NEVER(label, expr, msg) \
  `CRM_ASSERT(label, !(expr), msg)
`else
`define CRM_ASSERT(label, prop, msg)
`define CRM_NEVER(label, expr, msg)
`endif
`endif

// ===== rtl/crm_pkg.sv =====
// Types and constants of the command retry manager.
package crm_pkg;

  // Slot count, the index width that follows from it, and the mask width.
  localparam int NUM_KINDS = 16;
  localparam int KIND_W    = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
  localparam int MASK_W    = 16;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ATTEMPTS = 1'd1;
  localparam logic [15:0] INTERVAL_RESET  = 16'd500;
  localparam logic [3:0]  MAX_ATT_RESET   = 4'd5;
  localparam logic [3:0]  ATTEMPT_CEIL    = 4'd15;

  // Operation codes.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Result kinds and status codes.
  localparam logic       EV_SEND     = 1'b0;
  localparam logic       EV_STATUS   = 1'b1;
  localparam logic [2:0] ST_SENDING  = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;

  // Input word.
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  cmd_kind;
    logic [31:0] cmd_handle;
    logic [2:0]  finish_status;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic        event_kind;
    logic [3:0]  slot_kind;
    logic [31:0] handle_out;
    logic [3:0]  attempt;
    logic [2:0]  status_code;
    logic [15:0] pending_mask;
    logic        last_result;
  } out_word_t;

  // One entry of the slot memory.
  typedef struct packed {
    logic [31:0] handle;
    logic [3:0]  attempt;
    logic [15:0] countdown;
  } slot_t;

endpackage

// ===== rtl/command_retry_manager.sv =====
// Top level of the command retry manager: slot memory, tick sequencer and result register.
//
//   channel   dir  payload     handshake
//   in        in   in_word_t   in_valid / in_ready
//   out       out  out_word_t  out_valid / out_ready
//   cfg       in   16 bits     cfg_wr_en, cfg_index
//
// An add steps through accept, then two result words; a finish through accept and one word.
// A tick runs a prescan of the slot memory that finds the final pending mask,
// then a second pass over the one read port and one write port that updates
// the slots and emits the words, with a rejection word after each rejected slot.
// A stalled output holds the sequencer in place. Reset clears all slots at once.
`include "assert_macros.svh"

module command_retry_manager import crm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_data,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int SHOW = (NUM_KINDS < MASK_W) ? NUM_KINDS : MASK_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ADD_SEND = 3'd1;
  localparam logic [2:0] S_ADD_STAT = 3'd2;
  localparam logic [2:0] S_FIN      = 3'd3;
  localparam logic [2:0] S_PRE      = 3'd4;
  localparam logic [2:0] S_WALK     = 3'd5;
  localparam logic [2:0] S_REJ      = 3'd6;

  logic [2:0]           state, state_next;
  logic [KIND_W-1:0]    idx, idx_next;
  logic [NUM_KINDS-1:0] slot_valid, valid_next;
  logic [NUM_KINDS-1:0] drop, drop_next;
  logic [NUM_KINDS-1:0] fire, fire_next;
  logic [15:0]          interval_ticks;
  logic [3:0]           max_attempts;
  logic [KIND_W-1:0]    item_kind, item_kind_next;
  logic [31:0]          item_handle, item_handle_next;
  logic [2:0]           item_status, item_status_next;

  // Slot memory with a registered read port.
  slot_t             slot_mem [NUM_KINDS];
  slot_t             slot_rd;
  logic              mem_we, mem_re;
  logic [KIND_W-1:0] mem_wa, mem_ra;
  slot_t             mem_wd;

  logic              out_load, out_free;
  out_word_t         res;
  logic [MASK_W-1:0] pend_mask;
  logic [NUM_KINDS-1:0] live, idx_bit;
  logic              kind_ok, cur_valid, e_expire, e_reject, others, last_idx, advance;
  logic [KIND_W-1:0] in_kind;
  logic [3:0]        att_inc;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Decode of the current item and of the slot word on the read port.
  assign in_kind   = KIND_W'(in_data.cmd_kind);
  assign kind_ok   = (int'(in_data.cmd_kind) < NUM_KINDS);
  assign cur_valid = slot_valid[idx];
  assign e_expire  = (slot_rd.countdown <= 16'd1);
  assign att_inc   = (slot_rd.attempt == ATTEMPT_CEIL) ? slot_rd.attempt
                                                        : slot_rd.attempt + 4'd1;
  assign e_reject  = (att_inc >= max_attempts);
  assign idx_bit   = NUM_KINDS'(1) << idx;
  assign others    = |(fire & ~idx_bit);
  assign last_idx  = (idx == KIND_W'(NUM_KINDS - 1));

  // Slots still pending once the current item is done; dropped slots are
  // known from the prescan before the first result of a tick leaves.
  assign live = slot_valid & ~drop;
  always_comb begin
    pend_mask = '0;
    for (int k = 0; k < SHOW; k++) begin
      pend_mask[k] = live[k];
    end
  end

  // Sequencer: item decode, prescan, update pass and result selection.
  always_comb begin
    state_next       = state;
    idx_next         = idx;
    valid_next       = slot_valid;
    drop_next        = drop;
    fire_next        = fire;
    item_kind_next   = item_kind;
    item_handle_next = item_handle;
    item_status_next = item_status;
    mem_we           = 1'b0;
    mem_wa           = idx;
    mem_wd           = slot_rd;
    mem_re           = 1'b0;
    mem_ra           = idx;
    out_load         = 1'b0;
    res              = '0;
    advance          = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          drop_next        = '0;
          fire_next        = '0;
          item_kind_next   = in_kind;
          item_handle_next = in_data.cmd_handle;
          item_status_next = in_data.finish_status;
          case (in_data.op)
            OP_ADD: begin
              if (kind_ok) begin
                mem_we               = 1'b1;
                mem_wa               = in_kind;
                mem_wd.handle        = in_data.cmd_handle;
                mem_wd.attempt       = '0;
                mem_wd.countdown     = interval_ticks;
                valid_next[in_kind]  = 1'b1;
                state_next           = S_ADD_SEND;
              end
            end
            OP_FINISH: begin
              if (kind_ok && slot_valid[in_kind]) begin
                valid_next[in_kind] = 1'b0;
                mem_re              = 1'b1;
                mem_ra              = in_kind;
                state_next          = S_FIN;
              end
            end
            OP_TICK: begin
              mem_re     = 1'b1;
              mem_ra     = '0;
              idx_next   = '0;
              state_next = S_PRE;
            end
            default: ;
          endcase
        end
      end
      S_ADD_SEND: begin
        if (out_free) begin
          out_load   = 1'b1;
          res        = '{EV_SEND, 4'(item_kind), item_handle, 4'd0, ST_SENDING,
                         pend_mask, 1'b0};
          state_next = S_ADD_STAT;
        end
      end
      S_ADD_STAT: begin
        if (out_free) begin
          out_load   = 1'b1;
          res        = '{EV_STATUS, 4'(item_kind), item_handle, 4'd0, ST_SENDING,
                         pend_mask, 1'b1};
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          res        = '{EV_STATUS, 4'(item_kind), slot_rd.handle, 4'd0, item_status,
                         pend_mask, 1'b1};
          state_next = S_IDLE;
        end
      end
      S_PRE: begin
        // Read-only pass: mark slots that fire and slots that get rejected.
        if (cur_valid && e_expire) begin
          fire_next[idx] = 1'b1;
          if (e_reject) begin
            drop_next[idx] = 1'b1;
          end
        end
        mem_re = 1'b1;
        if (last_idx) begin
          mem_ra     = '0;
          idx_next   = '0;
          state_next = S_WALK;
        end else begin
          mem_ra   = idx + 1'b1;
          idx_next = idx + 1'b1;
        end
      end
      S_WALK: begin
        if (!cur_valid) begin
          advance = 1'b1;
        end else if (!e_expire) begin
          mem_we           = 1'b1;
          mem_wd.countdown = slot_rd.countdown - 16'd1;
          advance          = 1'b1;
        end else if (out_free) begin
          out_load = 1'b1;
          res      = '{EV_SEND, 4'(idx), slot_rd.handle, att_inc, ST_SENDING,
                       pend_mask, !e_reject && !others};
          if (e_reject) begin
            valid_next[idx] = 1'b0;
            state_next      = S_REJ;
          end else begin
            mem_we           = 1'b1;
            mem_wd.attempt   = att_inc;
            mem_wd.countdown = interval_ticks;
            advance          = 1'b1;
          end
        end
      end
      S_REJ: begin
        if (out_free) begin
          out_load = 1'b1;
          res      = '{EV_STATUS, 4'(idx), slot_rd.handle, 4'd0, ST_REJECTED,
                       pend_mask, !others};
          advance  = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Step to the next slot of the update pass, or finish the tick.
    if (advance) begin
      fire_next[idx] = 1'b0;
      if (last_idx) begin
        state_next = S_IDLE;
      end else begin
        mem_re     = 1'b1;
        mem_ra     = idx + 1'b1;
        idx_next   = idx + 1'b1;
        state_next = S_WALK;
      end
    end
  end

  // Slot memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      slot_rd <= slot_mem[mem_ra];
    end
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      idx            <= '0;
      slot_valid     <= '0;
      drop           <= '0;
      fire           <= '0;
      out_valid      <= 1'b0;
      interval_ticks <= INTERVAL_RESET;
      max_attempts   <= MAX_ATT_RESET;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      slot_valid <= valid_next;
      drop       <= drop_next;
      fire       <= fire_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_INTERVAL:     interval_ticks <= cfg_wdata;
          REG_MAX_ATTEMPTS: max_attempts   <= cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
  end

  // Item and result words.
  always_ff @(posedge clk) begin
    item_kind   <= item_kind_next;
    item_handle <= item_handle_next;
    item_status <= item_status_next;
    if (out_load) begin
      out_data <= res;
    end
  end

  // The update pass never reads the entry it writes in the same cycle.
  `CRM_NEVER(a_mem_collide, mem_we && mem_re && (mem_wa == mem_ra), "slot read/write collision")
  // Every slot the prescan marked for rejection is freed by the end of the tick.
  `CRM_ASSERT(a_idle_drop, (state == S_IDLE) |-> ((slot_valid & drop) == '0), "dropped slot live")
  // Every firing slot has been visited by the end of the tick.
  `CRM_ASSERT(a_idle_fire, (state == S_IDLE) |-> (fire == '0), "firing slot not visited")
  // A rejection word only follows a slot that the prescan marked and that is now free.
  `CRM_ASSERT(a_rej_freed, (state == S_REJ) |-> (!slot_valid[idx] && drop[idx]), "bad reject")

endmodule
